/* design/ffha_pkg.sv */
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared constants, codes and types of the first-fit heap allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ffha_pkg;

    localparam int HEAP_BYTES   = 4096;
    localparam int HEADER_BYTES = 24;
    localparam int MAX_BLOCKS   = 128;

    // field widths fixed by the request/response format
    localparam int CMD_W  = 2;
    localparam int SIZE_W = 13;
    localparam int ADDR_W = 12;
    localparam int TOP_W  = 13;
    localparam int STS_W  = 2;
    localparam int SUM_W  = 15;

    localparam int ADDR_LIMIT = 2 ** ADDR_W;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_RESET = 2'd2
    } t_cmd;

    typedef enum logic [STS_W-1:0] {
        STS_OK      = 2'd0,
        STS_NOMEM   = 2'd1,
        STS_FULL    = 2'd2,
        STS_BADADDR = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_ALLOC,
        ST_SCAN_FREE,
        ST_MERGE,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [SIZE_W-1:0] request_size;
        logic [ADDR_W-1:0] payload_address;
    } t_req;

    typedef struct packed {
        logic [ADDR_W-1:0] result_address;
        logic [STS_W-1:0]  status;
        logic [TOP_W-1:0]  used_bytes;
    } t_result;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] size;
        logic              is_free;
    } t_entry;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        t_entry           wr_data;
    } t_tbl_req;

endpackage

`default_nettype wire

/* design/ffha_if.sv */
// ----------------------------------------------------------------------------
// ffha_if
// Valid/ready channels for allocator requests and responses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ffha_req_if;
    import ffha_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [SIZE_W-1:0] request_size;
    logic [ADDR_W-1:0] payload_address;

    modport source (output valid, command, request_size, payload_address, input ready);
    modport sink   (input valid, command, request_size, payload_address, output ready);
endinterface

interface ffha_rsp_if;
    import ffha_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] result_address;
    logic [STS_W-1:0]  status;
    logic [TOP_W-1:0]  used_bytes;

    modport source (output valid, result_address, status, used_bytes, input ready);
    modport sink   (input valid, result_address, status, used_bytes, output ready);
endinterface

`default_nettype wire

/* design/ffha_table.sv */
// ----------------------------------------------------------------------------
// ffha_table
// Block table memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffha_table (
    input  wire logic               i_clk,
    input  wire ffha_pkg::t_tbl_req i_tbl,
    output ffha_pkg::t_entry        o_rd_data
);
    import ffha_pkg::*;

    t_entry r_mem [MAX_BLOCKS];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_tbl.wr_en) begin
            r_mem[i_tbl.wr_addr] <= i_tbl.wr_data;
        end
        if (i_tbl.rd_en) begin
            r_rd_data <= r_mem[i_tbl.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* design/ffha_ctrl.sv */
// ----------------------------------------------------------------------------
// ffha_ctrl
// Sequencer that walks the block table through one shared adder/compare:
// first-fit search, free lookup, forward coalescing and top carving.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffha_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire ffha_pkg::t_req     i_req,
    output logic                    o_idle,
    output logic                    o_done,
    output ffha_pkg::t_result       o_res,
    input  wire logic               i_rsp_free,
    output ffha_pkg::t_tbl_req      o_tbl,
    input  wire ffha_pkg::t_entry   i_rd
);
    import ffha_pkg::*;

    t_state              r_state, n_state;
    logic [SIZE_W-1:0]   r_want, n_want;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic                r_pend, n_pend;
    logic [IDX_W-1:0]    r_pidx, n_pidx;
    logic [IDX_W-1:0]    r_hit, n_hit;
    logic [ADDR_W-1:0]   r_hstart, n_hstart;
    logic [SIZE_W-1:0]   r_acc, n_acc;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [TOP_W-1:0]    r_top, n_top;
    t_result             r_res, n_res;
    logic [MAX_BLOCKS-1:0] r_live;

    // shared adder: opa + opb + header
    logic [TOP_W-1:0]  w_opa;
    logic [SIZE_W-1:0] w_opb;
    logic [SUM_W-1:0]  w_sum;

    logic              w_more;
    logic              w_step;
    logic              w_live_set;
    logic              w_live_clr;
    logic              w_live_clr_all;
    logic [IDX_W-1:0]  w_live_idx;
    logic              w_pend_live;

    assign w_sum       = SUM_W'(w_opa) + SUM_W'(w_opb) + SUM_W'(HEADER_BYTES);
    assign w_more      = (r_idx < r_count);
    assign w_pend_live = r_pend && r_live[r_pidx];

    always_comb begin
        w_opa = '0;
        w_opb = '0;
        unique case (r_state)
            ST_SCAN_ALLOC: begin
                if (r_pend) begin
                    w_opa = TOP_W'(i_rd.start);
                end else begin
                    w_opa = r_top;
                    w_opb = r_want;
                end
            end
            ST_SCAN_FREE: w_opa = TOP_W'(i_rd.start);
            ST_MERGE: begin
                w_opa = r_acc;
                w_opb = i_rd.size;
            end
            ST_IDLE, ST_RESP: begin
                w_opa = '0;
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_want   = r_want;
        n_addr   = r_addr;
        n_idx    = r_idx;
        n_pend   = r_pend;
        n_pidx   = r_pidx;
        n_hit    = r_hit;
        n_hstart = r_hstart;
        n_acc    = r_acc;
        n_count  = r_count;
        n_top    = r_top;
        n_res    = r_res;
        o_tbl    = '0;
        o_done   = 1'b0;
        w_step   = 1'b0;
        w_live_set     = 1'b0;
        w_live_clr     = 1'b0;
        w_live_clr_all = 1'b0;
        w_live_idx     = r_pidx;

        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_want = i_req.request_size;
                    n_addr = i_req.payload_address;
                    n_idx  = '0;
                    n_pend = 1'b0;
                    n_res  = '{result_address: '0, status: STS_OK, used_bytes: r_top};
                    unique case (i_req.command)
                        CMD_ALLOC: n_state = ST_SCAN_ALLOC;
                        CMD_FREE: begin
                            if (i_req.payload_address == '0) begin
                                n_state = ST_RESP;
                            end else begin
                                n_state = ST_SCAN_FREE;
                            end
                        end
                        CMD_RESET: begin
                            w_live_clr_all = 1'b1;
                            n_count = '0;
                            n_top   = '0;
                            n_res.used_bytes = '0;
                            n_state = ST_RESP;
                        end
                        default: n_state = ST_RESP;
                    endcase
                end
            end

            ST_SCAN_ALLOC: begin
                if (w_pend_live && i_rd.is_free && (i_rd.size >= r_want)) begin
                    // first fit: reuse as is, no split
                    o_tbl.wr_en   = 1'b1;
                    o_tbl.wr_addr = r_pidx;
                    o_tbl.wr_data = '{start: i_rd.start, size: i_rd.size, is_free: 1'b0};
                    n_res = '{result_address: w_sum[ADDR_W-1:0], status: STS_OK,
                              used_bytes: r_top};
                    n_pend  = 1'b0;
                    n_state = ST_RESP;
                end else if (!r_pend && !w_more) begin
                    // nothing fits: carve at the top, or fail with no memory or a full table
                    n_state = ST_RESP;
                    if ((w_sum > SUM_W'(HEAP_BYTES)) ||
                        (r_top >= TOP_W'(ADDR_LIMIT - HEADER_BYTES))) begin
                        n_res = '{result_address: '0, status: STS_NOMEM, used_bytes: r_top};
                    end else if (r_count >= CNT_W'(MAX_BLOCKS)) begin
                        n_res = '{result_address: '0, status: STS_FULL, used_bytes: r_top};
                    end else begin
                        o_tbl.wr_en   = 1'b1;
                        o_tbl.wr_addr = r_count[IDX_W-1:0];
                        o_tbl.wr_data = '{start: r_top[ADDR_W-1:0], size: r_want,
                                          is_free: 1'b0};
                        w_live_set = 1'b1;
                        w_live_idx = r_count[IDX_W-1:0];
                        n_count = r_count + CNT_W'(1);
                        n_top   = w_sum[TOP_W-1:0];
                        n_res = '{result_address: ADDR_W'(SUM_W'(r_top) + SUM_W'(HEADER_BYTES)),
                                  status: STS_OK, used_bytes: w_sum[TOP_W-1:0]};
                    end
                end else begin
                    w_step = 1'b1;
                end
            end

            ST_SCAN_FREE: begin
                if (w_pend_live && (w_sum == SUM_W'(r_addr))) begin
                    n_hit    = r_pidx;
                    n_hstart = i_rd.start;
                    n_acc    = i_rd.size;
                    n_idx    = CNT_W'(r_pidx) + CNT_W'(1);
                    n_pend   = 1'b0;
                    n_state  = ST_MERGE;
                end else if (!r_pend && !w_more) begin
                    n_res = '{result_address: '0, status: STS_BADADDR, used_bytes: r_top};
                    n_state = ST_RESP;
                end else begin
                    w_step = 1'b1;
                end
            end

            ST_MERGE: begin
                if ((w_pend_live && !i_rd.is_free) || (!r_pend && !w_more)) begin
                    // run of free successors ended: write the merged block back
                    o_tbl.wr_en   = 1'b1;
                    o_tbl.wr_addr = r_hit;
                    o_tbl.wr_data = '{start: r_hstart, size: r_acc, is_free: 1'b1};
                    n_res = '{result_address: '0, status: STS_OK, used_bytes: r_top};
                    n_pend  = 1'b0;
                    n_state = ST_RESP;
                end else begin
                    if (w_pend_live) begin
                        n_acc      = w_sum[SIZE_W-1:0];
                        w_live_clr = 1'b1;
                    end
                    w_step = 1'b1;
                end
            end

            ST_RESP: begin
                if (i_rsp_free) begin
                    o_done  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
        endcase

        // pipelined table walk: issue next entry, inspect it in the next cycle
        if (w_step) begin
            if (w_more) begin
                o_tbl.rd_en   = 1'b1;
                o_tbl.rd_addr = r_idx[IDX_W-1:0];
                n_pend = 1'b1;
                n_pidx = r_idx[IDX_W-1:0];
                n_idx  = r_idx + CNT_W'(1);
            end else begin
                n_pend = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pend  <= 1'b0;
            r_count <= '0;
            r_top   <= '0;
            r_live  <= '0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_count <= n_count;
            r_top   <= n_top;
            if (w_live_clr_all) begin
                r_live <= '0;
            end else if (w_live_set) begin
                r_live[w_live_idx] <= 1'b1;
            end else if (w_live_clr) begin
                r_live[w_live_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_want   <= n_want;
        r_addr   <= n_addr;
        r_idx    <= n_idx;
        r_pidx   <= n_pidx;
        r_hit    <= n_hit;
        r_hstart <= n_hstart;
        r_acc    <= n_acc;
        r_res    <= n_res;
    end

    assign o_idle = (r_state == ST_IDLE);
    assign o_res  = r_res;

endmodule

`default_nettype wire

/* design/first_fit_heap_allocator_top.sv */
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top
// Allocate and free walk the table slots in use; reset, a null free and unused
// commands answer without a walk.
// One request at a time, one table entry read per cycle; ready comes back as the
// response appears, unless an unread response still holds the output register.
// Synchronous reset clears heap top, slot count and live bits; no sweep.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module first_fit_heap_allocator_top (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ffha_req_if.sink    i_req,
    ffha_rsp_if.source  o_rsp
);
    import ffha_pkg::*;

    t_req     w_req;
    t_result  w_res;
    t_tbl_req w_tbl;
    t_entry   w_rd;
    logic     w_idle;
    logic     w_done;
    logic     w_accept;
    logic     w_rsp_free;

    logic     r_valid;
    t_result  r_out;

    assign w_req = '{command: i_req.command, request_size: i_req.request_size,
                     payload_address: i_req.payload_address};
    assign i_req.ready = w_idle;
    assign w_accept    = i_req.valid && w_idle;
    assign w_rsp_free  = !r_valid || o_rsp.ready;

    ffha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_req      (w_req),
        .o_idle     (w_idle),
        .o_done     (w_done),
        .o_res      (w_res),
        .i_rsp_free (w_rsp_free),
        .o_tbl      (w_tbl),
        .i_rd       (w_rd)
    );

    ffha_table u_table (
        .i_clk     (i_clk),
        .i_tbl     (w_tbl),
        .o_rd_data (w_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_done) begin
            r_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out <= w_res;
        end
    end

    assign o_rsp.valid          = r_valid;
    assign o_rsp.result_address = r_out.result_address;
    assign o_rsp.status         = r_out.status;
    assign o_rsp.used_bytes     = r_out.used_bytes;

    // any failure carries a null address
    a_fail_null: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status != STS_OK)) |-> (o_rsp.result_address == '0))
        else $error("failed request returned nonzero address");

    // heap top stays inside the heap
    a_top_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.used_bytes <= TOP_W'(HEAP_BYTES)))
        else $error("heap top beyond heap size");

    // a granted address always lies past a header
    a_addr_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.result_address != '0)) |->
            (o_rsp.result_address >= ADDR_W'(HEADER_BYTES)))
        else $error("payload address inside a header");

    // a new request never completes in the cycle it is taken
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> !w_done)
        else $error("response produced too early");

endmodule

`default_nettype wire

/* sim/tb_first_fit_heap_allocator_top.sv */
// ----------------------------------------------------------------------------
// tb_first_fit_heap_allocator_top
// Drives allocate/free/reset requests into the first-fit heap allocator and
// checks every response against a behavioral copy of the block table or a
// hand-written response. A short stimulus table hits the corner cases. Random
// episodes follow. Each episode starts with a heap reset and has a traffic
// profile: fill the table with tiny blocks, mixed churn, or large blocks that
// run out of memory. Both handshake sides idle at random in phases. One long
// response hold-off backs the allocator up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_first_fit_heap_allocator_top;
    import ffha_pkg::*;

    localparam int DIR_N        = 25;
    localparam int RAND_REQS    = 1525;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 300;
    localparam int CYCLE_LIMIT  = 2_000_000;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle;
    typedef enum int {PROF_FILL, PROF_MIX, PROF_BIG} t_profile;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] addr;
        logic              typed;
        t_result           rsp;
    } t_row;

    // rows with typed = 1 carry a hand-written response; the rest use the predictor
    localparam t_row DIR_ROWS [DIR_N] = '{
        '{CMD_ALLOC,  13'd0,    12'd0,    1'b1, '{12'd24, STS_OK,      13'd24}},
        '{CMD_FREE,   13'd0,    12'd0,    1'b1, '{12'd0,  STS_OK,      13'd24}},
        '{CMD_FREE,   13'd0,    12'd5,    1'b1, '{12'd0,  STS_BADADDR, 13'd24}},
        '{CMD_UNUSED, 13'd0,    12'd0,    1'b1, '{12'd0,  STS_OK,      13'd24}},
        '{CMD_ALLOC,  13'd4096, 12'd0,    1'b1, '{12'd0,  STS_NOMEM,   13'd24}},
        '{CMD_ALLOC,  13'd16,   12'd0,    1'b0, '0},
        '{CMD_FREE,   13'd0,    12'd24,   1'b0, '0},
        '{CMD_FREE,   13'd0,    12'd24,   1'b0, '0},
        '{CMD_ALLOC,  13'd0,    12'd0,    1'b0, '0},
        '{CMD_ALLOC,  13'd8,    12'd0,    1'b0, '0},
        '{CMD_FREE,   13'd0,    12'd48,   1'b0, '0},
        '{CMD_FREE,   13'd0,    12'd88,   1'b0, '0},
        '{CMD_FREE,   13'd0,    12'd24,   1'b0, '0},
        '{CMD_ALLOC,  13'd72,   12'd0,    1'b0, '0},
        '{CMD_FREE,   13'd0,    12'd48,   1'b1, '{12'd0,  STS_BADADDR, 13'd96}},
        '{CMD_RESET,  13'd0,    12'd0,    1'b1, '{12'd0,  STS_OK,      13'd0}},
        '{CMD_ALLOC,  13'd4048, 12'd0,    1'b0, '0},
        '{CMD_ALLOC,  13'd0,    12'd0,    1'b1, '{12'd0,  STS_NOMEM,   13'd4072}},
        '{CMD_FREE,   13'd0,    12'd4095, 1'b1, '{12'd0,  STS_BADADDR, 13'd4072}},
        '{CMD_RESET,  13'd0,    12'd0,    1'b1, '{12'd0,  STS_OK,      13'd0}},
        '{CMD_ALLOC,  13'd4072, 12'd0,    1'b0, '0},
        '{CMD_FREE,   13'd0,    12'd24,   1'b0, '0},
        '{CMD_ALLOC,  13'd4072, 12'd0,    1'b0, '0},
        '{CMD_RESET,  13'd0,    12'd0,    1'b1, '{12'd0,  STS_OK,      13'd0}},
        '{CMD_ALLOC,  13'd4096, 12'd0,    1'b1, '{12'd0,  STS_NOMEM,   13'd0}}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    ffha_req_if rq ();
    ffha_rsp_if rs ();

    first_fit_heap_allocator_top u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (rq),
        .o_rsp   (rs)
    );

    // shadow block table
    int blk_start [MAX_BLOCKS];
    int blk_size  [MAX_BLOCKS];
    bit blk_free  [MAX_BLOCKS];
    bit blk_live  [MAX_BLOCKS];
    int slot_count;
    int shadow_top;

    t_result     awaited_rsp [$];
    t_idle       idle_mode = IDLE_NONE;
    bit          hold_rsp  = 1'b0;
    int          reqs_sent = 0;
    int          errors    = 0;
    int unsigned cycle_cnt = 0;

    initial begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

    initial begin : watchdog
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // applies one request to the shadow table and returns the response it owes
    function automatic t_result next_heap_rsp(logic [CMD_W-1:0] cmd, int want, int addr);
        t_result r;
        int      i;
        int      hit;
        bit      found;
        bit      merging;
        r = '0;
        r.status = STS_OK;
        case (cmd)
            CMD_ALLOC: begin
                found = 1'b0;
                for (i = 0; i < slot_count; i++) begin
                    if (!found && blk_live[i] && blk_free[i] && blk_size[i] >= want) begin
                        found = 1'b1;
                        blk_free[i] = 1'b0;
                        r.result_address = ADDR_W'(blk_start[i] + HEADER_BYTES);
                    end
                end
                if (!found) begin
                    if (shadow_top + HEADER_BYTES + want > HEAP_BYTES ||
                        shadow_top + HEADER_BYTES >= ADDR_LIMIT) begin
                        r.status = STS_NOMEM;
                    end else if (slot_count >= MAX_BLOCKS) begin
                        r.status = STS_FULL;
                    end else begin
                        blk_start[slot_count] = shadow_top;
                        blk_size[slot_count]  = want;
                        blk_free[slot_count]  = 1'b0;
                        blk_live[slot_count]  = 1'b1;
                        slot_count++;
                        r.result_address = ADDR_W'(shadow_top + HEADER_BYTES);
                        shadow_top += HEADER_BYTES + want;
                    end
                end
            end
            CMD_FREE: begin
                if (addr != 0) begin
                    hit = -1;
                    for (i = 0; i < slot_count; i++) begin
                        if (hit < 0 && blk_live[i] && blk_start[i] + HEADER_BYTES == addr)
                            hit = i;
                    end
                    if (hit < 0) begin
                        r.status = STS_BADADDR;
                    end else begin
                        blk_free[hit] = 1'b1;
                        merging = 1'b1;
                        // absorb the run of free neighbors above, skipping dead slots
                        for (i = hit + 1; i < slot_count; i++) begin
                            if (merging && blk_live[i]) begin
                                if (!blk_free[i]) begin
                                    merging = 1'b0;
                                end else begin
                                    blk_size[hit] += HEADER_BYTES + blk_size[i];
                                    blk_live[i] = 1'b0;
                                end
                            end
                        end
                    end
                end
            end
            CMD_RESET: begin
                shadow_top = 0;
                slot_count = 0;
                for (i = 0; i < MAX_BLOCKS; i++) blk_live[i] = 1'b0;
            end
            default: ;
        endcase
        r.used_bytes = TOP_W'(shadow_top);
        return r;
    endfunction

    task automatic send_req(input logic [CMD_W-1:0] cmd, input int want, input int addr,
                            input bit typed, input t_result typed_rsp);
        t_result pred;
        int      seg;
        seg = (reqs_sent - DIR_N) * 5 / RAND_REQS;
        if (reqs_sent < DIR_N)
            idle_mode = IDLE_NONE;
        else
            idle_mode = (seg == 1) ? IDLE_SEND : (seg == 2) ? IDLE_RECV :
                        (seg == 3) ? IDLE_BOTH : IDLE_NONE;
        while ((idle_mode == IDLE_SEND && $urandom_range(0, 99) < 51) ||
               (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 15)) begin
            rq.valid <= 1'b0;
            @(posedge clk);
        end
        rq.valid           <= 1'b1;
        rq.command         <= cmd;
        rq.request_size    <= SIZE_W'(want);
        rq.payload_address <= ADDR_W'(addr);
        @(posedge clk);
        while (!rq.ready) @(posedge clk);
        pred = next_heap_rsp(cmd, want, addr);
        awaited_rsp.push_back(typed ? typed_rsp : pred);
        reqs_sent++;
    endtask

    initial begin : request_side
        int               k;
        int               ep_len;
        int               roll;
        int               alloc_pct;
        int               want;
        int               addr;
        logic [CMD_W-1:0] cmd;
        t_profile         profile;

        rq.valid           <= 1'b0;
        rq.command         <= CMD_ALLOC;
        rq.request_size    <= '0;
        rq.payload_address <= '0;
        rst_n              <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < DIR_N; k++)
            send_req(DIR_ROWS[k].command, DIR_ROWS[k].size, DIR_ROWS[k].addr,
                     DIR_ROWS[k].typed, DIR_ROWS[k].rsp);

        // long response back-pressure while requests keep coming
        hold_rsp = 1'b1;

        while (reqs_sent < DIR_N + RAND_REQS) begin
            profile = t_profile'($urandom_range(0, 2));
            ep_len  = (profile == PROF_FILL) ? $urandom_range(180, 300)
                                             : $urandom_range(30, 150);
            alloc_pct = (profile == PROF_FILL) ? 80 : (profile == PROF_MIX) ? 50 : 55;
            send_req(CMD_RESET, $urandom_range(0, 4096), $urandom_range(0, 4095), 1'b0, '0);
            for (k = 0; k < ep_len && reqs_sent < DIR_N + RAND_REQS; k++) begin
                roll = $urandom_range(0, 99);
                want = $urandom_range(0, 4096);
                addr = $urandom_range(0, 4095);
                if (roll < alloc_pct) begin
                    cmd = CMD_ALLOC;
                    case (profile)
                        PROF_FILL: want = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 24)
                                                                      : $urandom_range(0, 6);
                        PROF_MIX:  begin
                            roll = $urandom_range(0, 99);
                            want = (roll < 70) ? $urandom_range(0, 64) :
                                   (roll < 95) ? $urandom_range(0, 512) : want;
                        end
                        default:   if ($urandom_range(0, 1)) want = $urandom_range(64, 1024);
                    endcase
                end else if (roll < 93) begin
                    // free an existing slot; a dead (absorbed) slot gives a bad address
                    cmd = CMD_FREE;
                    if (slot_count > 0)
                        addr = blk_start[$urandom_range(0, slot_count - 1)] + HEADER_BYTES;
                end else if (roll < 96) begin
                    cmd = CMD_FREE;
                end else if (roll < 98) begin
                    cmd  = CMD_FREE;
                    addr = 0;
                end else if (roll < 99) begin
                    cmd = CMD_UNUSED;
                end else begin
                    cmd = CMD_RESET;
                end
                send_req(cmd, want, addr, 1'b0, '0);
            end
        end

        rq.valid <= 1'b0;
        while (awaited_rsp.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : response_side
        t_result want;
        int      hold_left;
        hold_left = 0;
        rs.ready <= 1'b0;
        while (!rst_n) @(posedge clk);
        forever begin
            @(posedge clk);
            if (rs.valid && rs.ready) begin
                if (awaited_rsp.size() == 0) begin
                    $display("%0t: response with no request pending: addr %0d status %0d used %0d",
                             $time, rs.result_address, rs.status, rs.used_bytes);
                    errors++;
                end else begin
                    want = awaited_rsp.pop_front();
                    if (rs.result_address !== want.result_address) begin
                        $display("%0t: result_address expected %0d, got %0d",
                                 $time, want.result_address, rs.result_address);
                        errors++;
                    end
                    if (rs.status !== want.status) begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, rs.status);
                        errors++;
                    end
                    if (rs.used_bytes !== want.used_bytes) begin
                        $display("%0t: used_bytes expected %0d, got %0d",
                                 $time, want.used_bytes, rs.used_bytes);
                        errors++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                rs.ready <= 1'b0;
            end else if (hold_rsp) begin
                hold_rsp  = 1'b0;
                hold_left = HOLD_CYCLES;
                rs.ready <= 1'b0;
            end else begin
                rs.ready <= !((idle_mode == IDLE_RECV && $urandom_range(0, 99) < 51) ||
                              (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 15));
            end
        end
    end

endmodule

/* filelist.f */
design/ffha_pkg.sv
design/ffha_if.sv
design/ffha_table.sv
design/ffha_ctrl.sv
design/first_fit_heap_allocator_top.sv
sim/tb_first_fit_heap_allocator_top.sv
